// ===== design/vtcsr_pkg.sv =====
// shared types and constants for the voxel terrain column span renderer
// no dependencies; imported by every module of the block
package vtcsr_pkg;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_FRAME  = 2'd1,
        FUNC_ROW    = 2'd2,
        FUNC_SAMPLE = 2'd3
    } func_t;

    // projected row width, stored colour width, divider widths
    localparam int YW    = 18;
    localparam int CLR_W = 24;
    localparam int NUM_W = 25;
    localparam int DIV_W = 33;
    localparam int DVS_W = 16;

    typedef struct packed {
        func_t              func;
        logic [15:0]        map_addr;
        logic [7:0]         height_val;
        logic [7:0]         color_val;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [32:0] delta_x;
        logic signed [32:0] delta_y;
        logic signed [9:0]  eye_height;
        logic [15:0]        depth_scale;
    } cmd_t;

    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] dividend;
        logic [DVS_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== design/vtcsr_div.sv =====
// radix-2 restoring divider, signed dividend, unsigned divisor
// quotient truncated toward zero; depends on vtcsr_pkg
module vtcsr_div (
    input  logic                clk,
    input  logic                rst_n,
    input  vtcsr_pkg::div_req_t req,
    output vtcsr_pkg::div_rsp_t rsp
);
    import vtcsr_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            neg_next  = req.dividend[DIV_W-1];
            rem_next  = '0;
            dvs_next  = req.divisor;
            // magnitude of the most negative value still fits unsigned
            quo_next  = req.dividend[DIV_W-1] ? DIV_W'(-req.dividend) : DIV_W'(req.dividend);
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DVS_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// ===== design/vtcsr_front.sv =====
// front end: takes input transfers, classifies them and queues commands
// two-entry command queue towards the back end; depends on vtcsr_pkg
module vtcsr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // map_addr, height_val, color_val, start_x, start_y, end_x, end_y,
    // eye_height, depth_scale, zero pad
    input  logic [191:0]      s_tdata,
    // func
    input  logic [1:0]        s_tuser,
    output logic              q_valid,
    input  logic              q_pop,
    output vtcsr_pkg::cmd_t   q_cmd
);
    import vtcsr_pkg::*;

    localparam int Q_DEPTH = 2;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    cmd_t              fifo_mem [Q_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0]   count_reg, count_next;
    logic              push;
    cmd_t              cmd_in;
    logic signed [31:0] end_x, end_y;

    always_comb
    begin
        cmd_in.func        = func_t'(s_tuser);
        cmd_in.map_addr    = s_tdata[15:0];
        cmd_in.height_val  = s_tdata[23:16];
        cmd_in.color_val   = s_tdata[31:24];
        cmd_in.start_x     = s_tdata[63:32];
        cmd_in.start_y     = s_tdata[95:64];
        end_x              = s_tdata[127:96];
        end_y              = s_tdata[159:128];
        cmd_in.eye_height  = s_tdata[169:160];
        cmd_in.depth_scale = s_tdata[185:170];
        // ray spans in 33 bits so the difference cannot overflow
        cmd_in.delta_x = {end_x[31], end_x} - {cmd_in.start_x[31], cmd_in.start_x};
        cmd_in.delta_y = {end_y[31], end_y} - {cmd_in.start_y[31], cmd_in.start_y};
    end

    assign s_tready = (count_reg != QC_W'(Q_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + QC_W'(1);
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - QC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QP_W'(1);
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QP_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== design/vtcsr_back.sv =====
// back end: map and column memories, sampling sequencer and span output register
// depends on vtcsr_pkg and vtcsr_div
module vtcsr_back #(
    parameter int SCREEN_WIDTH = 320,
    parameter int SCREEN_ROWS  = 200,
    parameter int MAP_BITS     = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_pop,
    input  vtcsr_pkg::cmd_t q_cmd,
    output logic            m_tvalid,
    input  logic            m_tready,
    // column, top_row, bottom_row, color_start, color_step, zero pad
    output logic [79:0]     m_tdata
);
    import vtcsr_pkg::*;

    localparam int AW        = 2 * MAP_BITS;
    localparam int MAP_DEPTH = 1 << AW;
    localparam int CIW       = $clog2(SCREEN_WIDTH);
    localparam int CW        = $clog2(SCREEN_WIDTH + 1);
    localparam int RW        = $clog2(SCREEN_ROWS + 1);
    localparam int COLW      = 1 + CLR_W + RW;
    localparam int ROWS_HALF = SCREEN_ROWS / 2;

    // ray step by reciprocal multiplication, exact for 33-bit spans
    localparam int          DSH       = 32 + $clog2(SCREEN_WIDTH);
    localparam logic [33:0] RCP       = 34'(((64'd1 << DSH) + 64'(SCREEN_WIDTH) - 64'd1)
                                            / 64'(SCREEN_WIDTH));
    localparam int          RCP_CW    = 3;
    localparam int          RCP_STEPS = 5;

    typedef enum logic [14:0] {
        S_IDLE  = 15'h0001,
        S_CLEAR = 15'h0002,
        S_RAYX  = 15'h0004,
        S_RAYY  = 15'h0008,
        S_RD0   = 15'h0010,
        S_RD1   = 15'h0020,
        S_RD2   = 15'h0040,
        S_RD3   = 15'h0080,
        S_RD4   = 15'h0100,
        S_LERP1 = 15'h0200,
        S_LERP2 = 15'h0400,
        S_PROJ  = 15'h0800,
        S_CMP   = 15'h1000,
        S_DIV   = 15'h2000,
        S_FIN   = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    logic [CIW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]      col_idx_reg, col_idx_next;
    logic [31:0]        pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [31:0]        step_x_reg, step_x_next, step_y_reg, step_y_next;
    logic signed [9:0]  eye_reg, eye_next;
    logic [15:0]        scale_reg, scale_next;
    logic signed [32:0] dy_reg, dy_next;

    logic [RCP_CW-1:0]  rcp_cnt_reg, rcp_cnt_next;
    logic [39:0]        rcp_mag_reg, rcp_mag_next;
    logic [79:0]        rcp_acc_reg, rcp_acc_next;
    logic               rcp_neg_reg, rcp_neg_next;
    logic signed [32:0] rcp_src;
    logic [32:0]        rcp_abs;
    logic [41:0]        rcp_pp;
    logic [31:0]        rcp_step;

    logic [15:0]        map_mem [MAP_DEPTH];
    logic [15:0]        map_q;
    logic [AW-1:0]      map_ra, map_wa;
    logic               map_we;
    logic [15:0]        corner_reg [4];

    logic [COLW-1:0]    col_mem [SCREEN_WIDTH];
    logic [COLW-1:0]    col_q, col_wd;
    logic [CIW-1:0]     col_wa;
    logic               col_we;

    logic signed [17:0] top_h_reg, bot_h_reg, top_c_reg, bot_c_reg;
    logic signed [25:0] h_full, c_full;
    logic [7:0]         h_reg;
    logic [CLR_W-1:0]   c_reg;
    logic signed [10:0] h_rel;
    logic signed [27:0] proj;
    logic signed [YW-1:0] y_reg;

    logic               emit, emit_reg;
    logic [CLR_W-1:0]   from, from_reg;
    logic [RW-1:0]      last_reg;
    logic signed [YW-1:0] last_s;
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] sc_reg;

    logic               pull, stall, load;
    logic signed [25:0] cc;
    logic [RW-1:0]      bottom;
    logic [YW-1:0]      ytop;

    logic               m_tvalid_reg;
    logic [79:0]        m_tdata_reg;

    logic [MAP_BITS-1:0] u, v, u1, v1;

    div_req_t div_req;
    div_rsp_t div_rsp;

    vtcsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    function automatic logic signed [17:0] lerp8(input logic [7:0] p0, input logic [7:0] p1,
                                                 input logic [7:0] f);
        logic signed [8:0]  d;
        logic signed [17:0] prod;
        d    = $signed({1'b0, p1}) - $signed({1'b0, p0});
        prod = d * $signed({1'b0, f});
        return $signed({2'b00, p0, 8'h00}) + prod;
    endfunction

    function automatic logic signed [25:0] lerp18(input logic signed [17:0] t,
                                                  input logic signed [17:0] b,
                                                  input logic [7:0] f);
        logic signed [18:0] d;
        logic signed [27:0] prod;
        logic signed [27:0] sum;
        d    = {b[17], b} - {t[17], t};
        prod = d * $signed({1'b0, f});
        sum  = $signed({{2{t[17]}}, t, 8'h00}) + prod;
        return sum[25:0];
    endfunction

    // map coordinates wrap within the map side
    assign u  = pos_x_reg[16 +: MAP_BITS];
    assign v  = pos_y_reg[16 +: MAP_BITS];
    assign u1 = u + MAP_BITS'(1);
    assign v1 = v + MAP_BITS'(1);

    always_comb
    begin
        case (state_reg)
            S_RD1:   map_ra = {v, u1};
            S_RD2:   map_ra = {v1, u};
            S_RD3:   map_ra = {v1, u1};
            default: map_ra = {v, u};
        endcase
    end

    assign map_wa = AW'(q_cmd.map_addr);

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_wa] <= {q_cmd.color_val, q_cmd.height_val};
        end
        map_q <= map_mem[map_ra];
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[col_wa] <= col_wd;
        end
        col_q <= col_mem[col_idx_reg[CIW-1:0]];
    end

    // ray step: magnitude times reciprocal, eight bits per cycle, msb first
    assign rcp_src  = (state_reg == S_RAYX) ? dy_reg : q_cmd.delta_x;
    assign rcp_abs  = rcp_src[32] ? 33'(-rcp_src) : 33'(rcp_src);
    assign rcp_pp   = {34'd0, rcp_mag_reg[39:32]} * {8'd0, RCP};
    assign rcp_step = rcp_neg_reg ? -rcp_acc_reg[DSH +: 32] : rcp_acc_reg[DSH +: 32];

    // interpolation and projection datapath
    assign h_full = lerp18(top_h_reg, bot_h_reg, pos_y_reg[15:8]);
    assign c_full = lerp18(top_c_reg, bot_c_reg, pos_y_reg[15:8]);
    assign h_rel  = $signed({3'b000, h_reg}) - {eye_reg[9], eye_reg};
    assign proj   = h_rel * $signed({1'b0, scale_reg});

    // column compare
    assign last_s = $signed({{(YW - RW){1'b0}}, col_q[RW-1:0]});
    assign emit   = (y_reg < last_s);
    assign from   = col_q[COLW-1] ? col_q[RW +: CLR_W] : c_reg;
    assign num    = $signed({1'b0, c_reg}) - $signed({1'b0, from});

    // span finish
    assign pull   = (last_reg == RW'(SCREEN_ROWS));
    assign cc     = $signed({2'b00, from_reg}) + (pull ? {sc_reg[NUM_W-1], sc_reg} : 26'sd0);
    assign bottom = pull ? RW'(SCREEN_ROWS - 1) : last_reg;
    assign ytop   = y_reg[YW-1] ? '0 : y_reg;
    assign stall  = emit_reg && m_tvalid_reg && !m_tready;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        col_idx_next = col_idx_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        step_x_next  = step_x_reg;
        step_y_next  = step_y_reg;
        eye_next     = eye_reg;
        scale_next   = scale_reg;
        dy_next      = dy_reg;
        rcp_cnt_next = rcp_cnt_reg;
        rcp_mag_next = rcp_mag_reg;
        rcp_acc_next = rcp_acc_reg;
        rcp_neg_next = rcp_neg_reg;
        q_pop        = 1'b0;
        map_we       = 1'b0;
        col_we       = 1'b0;
        col_wa       = col_idx_reg[CIW-1:0];
        col_wd       = {1'b1, c_reg, emit_reg ? RW'(ytop) : last_reg};
        load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {{(DIV_W - NUM_W){num[NUM_W-1]}}, num};
        div_req.divisor  = DVS_W'(last_s - y_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.func)
                        FUNC_LOAD:
                        begin
                            map_we = 1'b1;
                        end
                        FUNC_FRAME:
                        begin
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        FUNC_ROW:
                        begin
                            pos_x_next    = q_cmd.start_x;
                            pos_y_next    = q_cmd.start_y;
                            eye_next      = q_cmd.eye_height;
                            scale_next    = q_cmd.depth_scale;
                            dy_next       = q_cmd.delta_y;
                            col_idx_next  = '0;
                            rcp_mag_next  = {7'd0, rcp_abs};
                            rcp_neg_next  = rcp_src[32];
                            rcp_acc_next  = '0;
                            rcp_cnt_next  = RCP_CW'(RCP_STEPS);
                            state_next    = S_RAYX;
                        end
                        FUNC_SAMPLE:
                        begin
                            // samples past the last column are dropped
                            if (col_idx_reg < CW'(SCREEN_WIDTH))
                            begin
                                state_next = S_RD0;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                col_we = 1'b1;
                col_wa = clr_cnt_reg;
                col_wd = {1'b0, {CLR_W{1'b0}}, RW'(SCREEN_ROWS)};
                clr_cnt_next = clr_cnt_reg + CIW'(1);
                if (clr_cnt_reg == CIW'(SCREEN_WIDTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_RAYX:
            begin
                if (rcp_cnt_reg != '0)
                begin
                    rcp_acc_next = {rcp_acc_reg[71:0], 8'h00} + 80'(rcp_pp);
                    rcp_mag_next = {rcp_mag_reg[31:0], 8'h00};
                    rcp_cnt_next = rcp_cnt_reg - RCP_CW'(1);
                end
                else
                begin
                    step_x_next  = rcp_step;
                    rcp_mag_next = {7'd0, rcp_abs};
                    rcp_neg_next = rcp_src[32];
                    rcp_acc_next = '0;
                    rcp_cnt_next = RCP_CW'(RCP_STEPS);
                    state_next   = S_RAYY;
                end
            end
            S_RAYY:
            begin
                if (rcp_cnt_reg != '0)
                begin
                    rcp_acc_next = {rcp_acc_reg[71:0], 8'h00} + 80'(rcp_pp);
                    rcp_mag_next = {rcp_mag_reg[31:0], 8'h00};
                    rcp_cnt_next = rcp_cnt_reg - RCP_CW'(1);
                end
                else
                begin
                    step_y_next = rcp_step;
                    state_next  = S_IDLE;
                end
            end
            S_RD0:   state_next = S_RD1;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_RD3;
            S_RD3:   state_next = S_RD4;
            S_RD4:   state_next = S_LERP1;
            S_LERP1: state_next = S_LERP2;
            S_LERP2: state_next = S_PROJ;
            S_PROJ:  state_next = S_CMP;
            S_CMP:
            begin
                if (emit)
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!stall)
                begin
                    load         = emit_reg;
                    col_we       = 1'b1;
                    pos_x_next   = pos_x_reg + step_x_reg;
                    pos_y_next   = pos_y_reg + step_y_reg;
                    col_idx_next = col_idx_reg + CW'(1);
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // reset runs the column clearing pass first
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            col_idx_reg  <= '0;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            step_x_reg   <= '0;
            step_y_reg   <= '0;
            eye_reg      <= '0;
            scale_reg    <= '0;
            rcp_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            col_idx_reg  <= col_idx_next;
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            step_x_reg   <= step_x_next;
            step_y_reg   <= step_y_next;
            eye_reg      <= eye_next;
            scale_reg    <= scale_next;
            rcp_cnt_reg  <= rcp_cnt_next;
            m_tvalid_reg <= load || (m_tvalid_reg && !m_tready);
        end
    end

    always_ff @(posedge clk)
    begin
        dy_reg      <= dy_next;
        rcp_mag_reg <= rcp_mag_next;
        rcp_acc_reg <= rcp_acc_next;
        rcp_neg_reg <= rcp_neg_next;
        case (state_reg)
            S_RD1: corner_reg[0] <= map_q;
            S_RD2: corner_reg[1] <= map_q;
            S_RD3: corner_reg[2] <= map_q;
            S_RD4: corner_reg[3] <= map_q;
            default:
            begin
            end
        endcase
        if (state_reg == S_LERP1)
        begin
            top_h_reg <= lerp8(corner_reg[0][7:0], corner_reg[1][7:0], pos_x_reg[15:8]);
            bot_h_reg <= lerp8(corner_reg[2][7:0], corner_reg[3][7:0], pos_x_reg[15:8]);
            top_c_reg <= lerp8(corner_reg[0][15:8], corner_reg[1][15:8], pos_x_reg[15:8]);
            bot_c_reg <= lerp8(corner_reg[2][15:8], corner_reg[3][15:8], pos_x_reg[15:8]);
        end
        if (state_reg == S_LERP2)
        begin
            h_reg <= h_full[23:16];
            c_reg <= c_full[CLR_W-1:0];
        end
        if (state_reg == S_PROJ)
        begin
            y_reg <= YW'(proj >>> 11) + YW'(ROWS_HALF);
        end
        if (state_reg == S_CMP)
        begin
            emit_reg <= emit;
            from_reg <= from;
            last_reg <= col_q[RW-1:0];
        end
        if (state_reg == S_DIV && div_rsp.done)
        begin
            sc_reg <= div_rsp.quotient[NUM_W-1:0];
        end
        if (load)
        begin
            m_tdata_reg <= {3'b000, {sc_reg[NUM_W-1], sc_reg}, cc, 8'(bottom), 8'(ytop),
                            9'(col_idx_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy || div_rsp.done)
        else $error("divider started while busy");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_rsp.busy || div_rsp.done))
        else $error("waiting on an idle divider");

    a_col_write: assert property (@(posedge clk) disable iff (!rst_n)
        col_we |-> (state_reg == S_CLEAR || state_reg == S_FIN))
        else $error("column store written outside clear or finish");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && stall) |=> (state_reg == S_FIN && $stable(m_tdata_reg)))
        else $error("span lost while output register full");
`endif

endmodule

// ===== design/voxel_terrain_column_span_renderer_unit.sv =====
// a sample runs four serial map reads and, when a span is emitted, the 33-step divider;
// a row start runs two reciprocal multiplications, a map load is a single map write, and
// a frame start runs a column clearing pass
// one item in flight in the back end; a two-entry queue keeps input flowing meanwhile
// reset: asynchronous active low, then a column clearing pass over all SCREEN_WIDTH columns
// top level; depends on vtcsr_pkg, vtcsr_front and vtcsr_back
module voxel_terrain_column_span_renderer_unit #(
    parameter int SCREEN_WIDTH = 320,
    parameter int SCREEN_ROWS  = 200,
    parameter int MAP_BITS     = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // map_addr, height_val, color_val, start_x, start_y, end_x, end_y,
    // eye_height, depth_scale, zero pad
    input  logic [191:0] s_tdata,
    // func
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // column, top_row, bottom_row, color_start, color_step, zero pad
    output logic [79:0]  m_tdata
);
    import vtcsr_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    vtcsr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd)
    );

    vtcsr_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_ROWS  (SCREEN_ROWS),
        .MAP_BITS     (MAP_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
